// ===== sv/esst_pkg.sv =====
// Shared types and constants for the exponential search table block.
// Used by esst_front, esst_back and the top level; depends on nothing.
`default_nettype none

package esst_pkg;

  localparam int DATA_W        = 32;
  localparam int POS_W         = 10;
  localparam int COUNT_W       = 11;
  localparam int DEFAULT_DEPTH = 1024;
  localparam int QUEUE_DEPTH   = 2;

  localparam logic [COUNT_W-1:0] COUNT_RESET = 11'd1024;

  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_SEARCH = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    KIND_WRITE,
    KIND_SKIP,
    KIND_SEARCH
  } kind_t;

  typedef struct packed {
    kind_t                     kind;
    logic [POS_W-1:0]          position;
    logic signed [DATA_W-1:0]  value;
  } item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ZERO,
    ST_DOUBLE,
    ST_SETUP,
    ST_BIN,
    ST_DONE
  } back_state_t;

endpackage

`default_nettype wire

// ===== sv/esst_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module esst_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== sv/esst_front.sv =====
// Front end: accepts input items, classifies them and queues them for the back end.
// Depends on esst_pkg.
`default_nettype none

module esst_front #(
  parameter int STORE_DEPTH = esst_pkg::DEFAULT_DEPTH
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic                             operation,
  input  wire logic [esst_pkg::POS_W-1:0]       position,
  input  wire logic signed [esst_pkg::DATA_W-1:0] value,
  output logic                                  q_valid,
  input  wire logic                             q_pop,
  output esst_pkg::item_t                       q_item
);

  import esst_pkg::*;

  localparam int QA = $clog2(QUEUE_DEPTH);

  item_t         slots [QUEUE_DEPTH];
  logic [QA-1:0] wr_ptr;
  logic [QA-1:0] rd_ptr;
  logic [QA:0]   count;
  item_t         item_in;
  logic          push;
  logic          pop;

  always_comb begin
    item_in.position = position;
    item_in.value    = value;
    unique case (op_t'(operation))
      OP_WRITE: begin
        item_in.kind = (32'(position) < 32'(STORE_DEPTH)) ? KIND_WRITE : KIND_SKIP;
      end
      OP_SEARCH: begin
        item_in.kind = KIND_SEARCH;
      end
      default: begin
        item_in.kind = KIND_SKIP;
      end
    endcase
  end

  assign in_ready = (count != (QA+1)'(QUEUE_DEPTH));
  assign q_valid  = (count != '0);
  assign push     = in_valid && in_ready;
  assign pop      = q_pop && q_valid;
  assign q_item   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QA'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QA'(1);
      end
      if (push && !pop) begin
        count <= count + (QA+1)'(1);
      end else if (pop && !push) begin
        count <= count - (QA+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= item_in;
    end
  end

endmodule

`default_nettype wire

// ===== sv/esst_back.sv =====
// Back end: table RAM, search sequencer and result register.
// Depends on esst_pkg and esst_ram.
`default_nettype none

module esst_back #(
  parameter int STORE_DEPTH = esst_pkg::DEFAULT_DEPTH
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic [esst_pkg::COUNT_W-1:0] entry_count,
  input  wire logic                         q_valid,
  output logic                              q_pop,
  input  wire esst_pkg::item_t              q_item,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic                              found,
  output logic [esst_pkg::POS_W-1:0]        match_index
);

  import esst_pkg::*;

  localparam int AW   = $clog2(STORE_DEPTH);
  localparam int PW   = AW + 1;
  localparam int SW   = PW + 1;
  localparam int CMPW = (PW > COUNT_W) ? PW : COUNT_W;

  back_state_t              state;
  back_state_t              state_next;
  logic signed [DATA_W-1:0] key;
  logic signed [DATA_W-1:0] rd_data;
  logic [PW-1:0]            n;
  logic [PW-1:0]            n_cfg;
  logic [CMPW-1:0]          cnt_ext;
  logic [PW-1:0]            probe;
  logic [PW-1:0]            probe_dbl;
  logic [PW-1:0]            bound;
  logic [PW-1:0]            lo;
  logic [PW-1:0]            hi;
  logic [PW-1:0]            mid;
  logic [PW-1:0]            lo_new;
  logic [PW-1:0]            hi_new;
  logic [PW-1:0]            mid_setup;
  logic [PW-1:0]            lo_lt;
  logic [PW-1:0]            hi_gt;
  logic [PW-1:0]            mid_lt;
  logic [PW-1:0]            mid_gt;
  logic                     ok_lt;
  logic                     ok_gt;
  logic                     eq;
  logic                     gt;
  logic                     found_r;
  logic [AW-1:0]            where_r;
  logic                     ram_we;
  logic                     ram_re;
  logic [AW-1:0]            ram_raddr;
  logic                     load_out;
  logic                     is_search;

  esst_ram #(
    .WIDTH (DATA_W),
    .DEPTH (STORE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(q_item.position)),
    .wdata (q_item.value),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (rd_data)
  );

  assign cnt_ext   = CMPW'(entry_count);
  assign n_cfg     = (cnt_ext > CMPW'(STORE_DEPTH)) ? PW'(STORE_DEPTH) : PW'(cnt_ext);
  assign is_search = q_valid && (q_item.kind == KIND_SEARCH);

  assign eq        = (rd_data == key);
  assign gt        = (rd_data > key);
  assign probe_dbl = probe << 1;

  // upper bound of the doubling phase, then the binary range it leaves
  assign bound     = (state == ST_ZERO) ? PW'(1) : (gt ? probe : probe_dbl);
  assign lo_new    = (bound >> 1) + PW'(1);
  assign hi_new    = ((bound < n) ? bound : n) - PW'(1);
  assign mid_setup = PW'((SW'(lo) + SW'(hi)) >> 1);

  assign lo_lt     = mid + PW'(1);
  assign hi_gt     = mid - PW'(1);
  assign ok_lt     = (lo_lt <= hi);
  assign ok_gt     = (lo <= hi_gt);
  assign mid_lt    = PW'((SW'(lo_lt) + SW'(hi)) >> 1);
  assign mid_gt    = PW'((SW'(lo) + SW'(hi_gt)) >> 1);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (is_search) begin
          state_next = (n_cfg == '0) ? ST_DONE : ST_ZERO;
        end
      end
      ST_ZERO: begin
        if (eq) begin
          state_next = ST_DONE;
        end else if (PW'(1) < n) begin
          state_next = ST_DOUBLE;
        end else begin
          state_next = ST_SETUP;
        end
      end
      ST_DOUBLE: begin
        if (eq) begin
          state_next = ST_DONE;
        end else if (gt || !(probe_dbl < n)) begin
          state_next = ST_SETUP;
        end
      end
      ST_SETUP: begin
        state_next = (lo <= hi) ? ST_BIN : ST_DONE;
      end
      ST_BIN: begin
        if (eq) begin
          state_next = ST_DONE;
        end else if (gt) begin
          state_next = ok_gt ? ST_BIN : ST_DONE;
        end else begin
          state_next = ok_lt ? ST_BIN : ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid || out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    q_pop     = 1'b0;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_raddr = '0;
    load_out  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        q_pop  = q_valid;
        ram_we = q_valid && (q_item.kind == KIND_WRITE);
        ram_re = is_search && (n_cfg != '0);
      end
      ST_ZERO: begin
        ram_re    = !eq && (PW'(1) < n);
        ram_raddr = AW'(1);
      end
      ST_DOUBLE: begin
        ram_re    = !eq && !gt && (probe_dbl < n);
        ram_raddr = AW'(probe_dbl);
      end
      ST_SETUP: begin
        ram_re    = (lo <= hi);
        ram_raddr = AW'(mid_setup);
      end
      ST_BIN: begin
        ram_re    = !eq && (gt ? ok_gt : ok_lt);
        ram_raddr = gt ? AW'(mid_gt) : AW'(mid_lt);
      end
      ST_DONE: begin
        load_out = !out_valid || out_ready;
      end
      default: begin
        q_pop = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (is_search) begin
          key     <= q_item.value;
          n       <= n_cfg;
          found_r <= 1'b0;
          where_r <= '0;
        end
      end
      ST_ZERO: begin
        found_r <= eq;
        probe   <= PW'(1);
        lo      <= lo_new;
        hi      <= hi_new;
      end
      ST_DOUBLE: begin
        if (eq) begin
          found_r <= 1'b1;
          where_r <= AW'(probe);
        end
        probe <= probe_dbl;
        lo    <= lo_new;
        hi    <= hi_new;
      end
      ST_SETUP: begin
        mid <= mid_setup;
      end
      ST_BIN: begin
        if (eq) begin
          found_r <= 1'b1;
          where_r <= AW'(mid);
        end else if (gt) begin
          hi  <= hi_gt;
          mid <= mid_gt;
        end else begin
          lo  <= lo_lt;
          mid <= mid_lt;
        end
      end
      default: begin
      end
    endcase
    if (load_out) begin
      found       <= found_r;
      match_index <= found_r ? POS_W'(where_r) : '0;
    end
  end

endmodule

`default_nettype wire

// ===== sv/exponential_search_sorted_table_top.sv =====
// Top level of the exponential search table: entry count register, front and back ends.
// Depends on esst_pkg, esst_front, esst_back and esst_ram.
//
// Input channel (in_valid/in_ready): an item with operation 0 writes value at
// position; operation 1 searches for value. Writes give no result; each search
// gives one result (found, match_index) on the output channel (out_valid/out_ready).
// cfg_wen/cfg_wdata set entry_count, the number of sorted entries searched; write
// it only while the block is idle.
// A two-entry queue parts the front end from the back end, so items are taken
// while a search runs or while a result waits for the receiver.
// A write is done in the idle state as it is popped from the queue. A search
// probes index 0, then doubles the probe index until it finds the key, reaches an
// entry above the key or reaches entry_count, then sets up and runs a binary search
// over the range left: up to log2(entry_count)+1 doubling probes and at most
// log2(entry_count)-1 binary probes. The single read port of the table RAM takes one
// probe a cycle. out_valid rises as the result is loaded into the result register.
// Reset empties the queue, drops any pending result and sets entry_count to 1024;
// table contents are undefined until written.
// When the receiver stalls, the result holds and the back end waits once the
// next search completes; the queue then fills and in_ready drops.
`default_nettype none

module exponential_search_sorted_table_top #(
  parameter int STORE_DEPTH = esst_pkg::DEFAULT_DEPTH
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_wen,
  input  wire logic [esst_pkg::COUNT_W-1:0]       cfg_wdata,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic                               operation,
  input  wire logic [esst_pkg::POS_W-1:0]         position,
  input  wire logic signed [esst_pkg::DATA_W-1:0] value,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic                                    found,
  output logic [esst_pkg::POS_W-1:0]              match_index
);

  import esst_pkg::*;

  logic [COUNT_W-1:0] entry_count;
  logic               q_valid;
  logic               q_pop;
  item_t              q_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= COUNT_RESET;
    end else if (cfg_wen) begin
      entry_count <= cfg_wdata;
    end
  end

  esst_front #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .operation (operation),
    .position  (position),
    .value     (value),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_item    (q_item)
  );

  esst_back #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .entry_count (entry_count),
    .q_valid     (q_valid),
    .q_pop       (q_pop),
    .q_item      (q_item),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .found       (found),
    .match_index (match_index)
  );

  a_reset_clears : assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("reset did not clear the queue and result register");

  a_miss_index_zero : assert property (@(posedge clk) disable iff (rst)
    out_valid && !found |-> match_index == '0)
    else $error("miss reported with a non-zero index");

  a_pop_needs_item : assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("back end popped an empty queue");

  a_full_queue_stalls : assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> q_valid)
    else $error("input stalled with an empty queue");

endmodule

`default_nettype wire
